/* rtl/assert_macros.svh */
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication checked on the following clock edge.
`define SPQ_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/spq_pkg.sv */
// Types and constants of the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int unsigned DepthDef  = 16;
  localparam int unsigned PrioW     = 4;
  localparam int unsigned PayloadW  = 16;
  localparam int unsigned FillW     = 5;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CLEAR  = 2'd2
  } spq_kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } spq_status_e;

  typedef struct packed {
    logic [PrioW-1:0]    prio;
    logic [PayloadW-1:0] payload;
  } spq_entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic       ins;
    logic       rem;
    spq_entry_t entry;
  } spq_ctrl_t;

endpackage

/* rtl/spq_cell.sv */
// One slot of the sorted queue: compare against the new entry and shift.
`timescale 1ns / 1ps
module spq_cell #(
  parameter int unsigned CntW = 5,
  parameter int unsigned Idx  = 0
) (
  input  logic               clk_i,
  input  logic [CntW-1:0]    count_i,
  input  spq_pkg::spq_ctrl_t ctrl_i,
  input  spq_pkg::spq_entry_t left_i,
  input  logic               left_keep_i,
  input  spq_pkg::spq_entry_t right_i,
  output spq_pkg::spq_entry_t entry_o,
  output logic               keep_o
);

  spq_pkg::spq_entry_t entry_q, entry_d;
  logic                occ;

  assign occ    = count_i > CntW'(Idx);
  // Stays put on insert: occupied and not above the new priority.
  assign keep_o = occ && (entry_q.prio <= ctrl_i.entry.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (!keep_o) begin
        entry_d = left_keep_i ? ctrl_i.entry : left_i;
      end
    end else if (ctrl_i.rem) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

/* rtl/sorted_priority_queue_top.sv */
// Top level of the sorted priority queue: controller, cell chain and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Bounded priority queue held as a chain of Depth cells in ascending priority
// order; equal priorities leave in arrival order. Each transaction (insert,
// remove head, clear) is handled with all cells comparing and shifting
// together; the result is registered, so it appears in the cycle after
// acceptance. A new transaction is taken every cycle as long as the result
// register is empty or being drained in the same cycle. An insert into a full
// queue reports full; a remove on an empty queue reports empty with zero data.
// fill_count is the stored count truncated to five bits.
module sorted_priority_queue_top #(
  parameter int unsigned Depth = spq_pkg::DepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic [spq_pkg::PrioW-1:0]     entry_priority_i,
  input  logic [spq_pkg::PayloadW-1:0]  payload_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [spq_pkg::PrioW-1:0]     out_priority_o,
  output logic [spq_pkg::PayloadW-1:0]  out_payload_o,
  output logic [spq_pkg::FillW-1:0]     fill_count_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [CntW-1:0]     count_q, count_d;
  logic                out_valid_q;
  logic [1:0]          status_q, status_d;
  spq_pkg::spq_entry_t out_q, out_d;
  logic                in_fire, full, empty;
  spq_pkg::spq_ctrl_t  ctrl;
  spq_pkg::spq_entry_t cells [Depth];
  logic                keep [Depth];
  logic [CntW+spq_pkg::FillW-1:0] count_ext;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = count_q == CntW'(Depth);
  assign empty      = count_q == '0;

  always_comb begin
    ctrl.ins           = 1'b0;
    ctrl.rem           = 1'b0;
    ctrl.entry.prio    = entry_priority_i;
    ctrl.entry.payload = payload_i;
    count_d            = count_q;
    status_d           = spq_pkg::STATUS_OK;
    out_d              = '0;
    case (kind_i)
      spq_pkg::KIND_INSERT: begin
        if (full) begin
          status_d = spq_pkg::STATUS_FULL;
        end else begin
          ctrl.ins = in_fire;
          count_d  = count_q + CntW'(1);
        end
      end
      spq_pkg::KIND_REMOVE: begin
        if (empty) begin
          status_d = spq_pkg::STATUS_EMPTY;
        end else begin
          ctrl.rem = in_fire;
          out_d    = cells[0];
          count_d  = count_q - CntW'(1);
        end
      end
      spq_pkg::KIND_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    spq_pkg::spq_entry_t left, right;
    logic                left_keep;
    if (i == 0) begin : g_head
      assign left      = ctrl.entry;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left      = cells[i-1];
      assign left_keep = keep[i-1];
    end
    if (i == Depth - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = cells[i+1];
    end
    spq_cell #(
      .CntW (CntW),
      .Idx  (i)
    ) u_cell (
      .clk_i       (clk_i),
      .count_i     (count_q),
      .ctrl_i      (ctrl),
      .left_i      (left),
      .left_keep_i (left_keep),
      .right_i     (right),
      .entry_o     (cells[i]),
      .keep_o      (keep[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q <= status_d;
      out_q    <= out_d;
    end
  end

  logic [spq_pkg::FillW-1:0] fill_q;
  assign count_ext = {{spq_pkg::FillW{1'b0}}, count_q};

  function automatic logic [spq_pkg::FillW-1:0] count_d_ext_lo(input logic [CntW-1:0] c);
    logic [CntW+spq_pkg::FillW-1:0] e;
    e = {{spq_pkg::FillW{1'b0}}, c};
    return e[spq_pkg::FillW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fill_q <= count_d_ext_lo(count_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_priority_o = out_q.prio;
  assign out_payload_o  = out_q.payload;
  assign fill_count_o   = fill_q;

  `SPQ_ASSERT(a_count_bound, (count_q <= CntW'(Depth)), "entry count above depth")
  `SPQ_ASSERT(a_fill_tracks, (count_ext[spq_pkg::FillW-1:0] == fill_count_o || !out_valid_o || in_fire), "fill count does not match stored count")
  `SPQ_ASSERT_NEXT(a_insert_grows, in_fire && kind_i == spq_pkg::KIND_INSERT && !full, count_q == $past(count_q) + CntW'(1), "accepted insert did not grow the queue")
  `SPQ_ASSERT_NEXT(a_empty_remove, in_fire && kind_i == spq_pkg::KIND_REMOVE && empty, status_o == spq_pkg::STATUS_EMPTY && out_priority_o == '0 && out_payload_o == '0, "remove on empty queue misreported")

endmodule

/* sim/spq_checker.sv */
// Result checker for the sorted priority queue: predicts each transaction and compares.
`timescale 1ns / 1ps
module spq_checker
  import spq_pkg::*;
#(
  parameter int unsigned Depth = DepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [1:0]          kind_i,
  input  logic [PrioW-1:0]    entry_priority_i,
  input  logic [PayloadW-1:0] payload_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [1:0]          status_i,
  input  logic [PrioW-1:0]    out_priority_i,
  input  logic [PayloadW-1:0] out_payload_i,
  input  logic [FillW-1:0]    fill_count_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  peak_fill_o,
  output int                  full_hits_o,
  output int                  empty_hits_o
);

  typedef struct packed {
    logic [1:0]          status;
    logic [PrioW-1:0]    prio;
    logic [PayloadW-1:0] payload;
    logic [FillW-1:0]    fill;
  } spq_result_t;

  // Shadow of the queue, kept in service order.
  spq_entry_t  slots [Depth];
  int unsigned stored;
  spq_result_t expected_results [$];

  task automatic report(input string msg);
    $display("%0t ns: ERROR %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      report($sformatf("%s expected %0d got %0d", name, want, got));
    end
  endtask

  function automatic spq_result_t apply_transaction(input logic [1:0] kind,
                                                    input logic [PrioW-1:0] prio,
                                                    input logic [PayloadW-1:0] tag);
    spq_result_t res;
    int unsigned pos;
    res = '0;
    case (kind)
      KIND_INSERT: begin
        if (stored >= Depth) begin
          res.status = STATUS_FULL;
          full_hits_o++;
        end else begin
          // goes behind every entry of equal or better priority
          pos = 0;
          while (pos < stored && slots[pos].prio <= prio) pos++;
          for (int unsigned i = stored; i > pos; i--) slots[i] = slots[i-1];
          slots[pos] = '{prio: prio, payload: tag};
          stored++;
        end
      end
      KIND_REMOVE: begin
        if (stored == 0) begin
          res.status = STATUS_EMPTY;
          empty_hits_o++;
        end else begin
          res.prio    = slots[0].prio;
          res.payload = slots[0].payload;
          for (int unsigned i = 0; i + 1 < stored; i++) slots[i] = slots[i+1];
          stored--;
        end
      end
      KIND_CLEAR: begin
        stored = 0;
      end
      default: ;  // unused kind leaves the queue alone
    endcase
    res.fill = stored[FillW-1:0];
    if (stored > peak_fill_o) peak_fill_o = stored;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    spq_result_t want;
    if (!rst_ni) begin
      stored = 0;
      expected_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
      peak_fill_o  = 0;
      full_hits_o  = 0;
      empty_hits_o = 0;
    end else begin
      // a result always belongs to an earlier transaction, so compare first
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report("result with no transaction outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(status_i));
          check_field("out_priority", 32'(want.prio), 32'(out_priority_i));
          check_field("out_payload", 32'(want.payload), 32'(out_payload_i));
          check_field("fill_count", 32'(want.fill), 32'(fill_count_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(apply_transaction(kind_i, entry_priority_i, payload_i));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

/* sim/tb_sorted_priority_queue_top.sv */
// Testbench top for the sorted priority queue: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module tb_sorted_priority_queue_top;
  import spq_pkg::*;

  localparam logic [1:0] KindUnused  = 2'd3;
  localparam int         RandomItems = 850;
  localparam int         SegmentLen  = 40;
  localparam int         IdleLimit   = 2000;
  localparam int         LongHold    = 80;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                in_valid_i       = 1'b0;
  logic                in_ready_o;
  logic [1:0]          kind_i           = KIND_INSERT;
  logic [PrioW-1:0]    entry_priority_i = '0;
  logic [PayloadW-1:0] payload_i        = '0;
  logic                out_valid_o;
  logic                out_ready_i      = 1'b0;
  logic [1:0]          status_o;
  logic [PrioW-1:0]    out_priority_o;
  logic [PayloadW-1:0] out_payload_o;
  logic [FillW-1:0]    fill_count_o;

  int fail_count, pending, peak_fill, full_hits, empty_hits;
  int kind_sent [4] = '{0, 0, 0, 0};
  int idle_cycles = 0;
  bit steady      = 1'b0;  // no gaps on either side
  bit hold_req    = 1'b0;  // asks the receiver for one long hold-off

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  sorted_priority_queue_top u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .kind_i,
    .entry_priority_i,
    .payload_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .out_priority_o,
    .out_payload_o,
    .fill_count_o
  );

  spq_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i       (in_ready_o),
    .kind_i,
    .entry_priority_i,
    .payload_i,
    .out_valid_i      (out_valid_o),
    .out_ready_i,
    .status_i         (status_o),
    .out_priority_i   (out_priority_o),
    .out_payload_i    (out_payload_o),
    .fill_count_i     (fill_count_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .peak_fill_o      (peak_fill),
    .full_hits_o      (full_hits),
    .empty_hits_o     (empty_hits)
  );

  // Watchdog: too long without any transaction on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("sorted_priority_queue_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [1:0] pick_kind(input int ins_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return KindUnused;
    if (r < 3) return KIND_CLEAR;
    if (r < 3 + ins_pct * 97 / 100) return KIND_INSERT;
    return KIND_REMOVE;
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic [PrioW-1:0] prio,
                           input logic [PayloadW-1:0] tag);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    kind_i           <= kind;
    entry_priority_i <= prio;
    payload_i        <= tag;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    kind_sent[kind]++;
  endtask

  // Receiver: bursts of ready, short and long stalls, one forced long hold on request.
  initial begin
    int  n;
    int  r;
    bit  level;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        level    = 1'b0;
        n        = LongHold;
      end else if (steady) begin
        level = 1'b1;
        n     = 8;
      end else begin
        r = $urandom_range(0, 9);
        if (r < 5) begin
          level = 1'b1;
          n     = $urandom_range(1, 20);
        end else if (r < 9) begin
          level = 1'b0;
          n     = $urandom_range(1, 3);
        end else begin
          level = 1'b0;
          n     = $urandom_range(10, 40);
        end
      end
      repeat (n) begin
        out_ready_i <= level;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int         seg;
    int         sent;
    int         ins_pct;
    bit         narrow;
    logic [1:0] k;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty remove, extremes, ties in arrival order, unused kind, clear
    send_item(KIND_REMOVE, 4'h0, 16'h0000);
    send_item(KIND_INSERT, 4'hf, 16'hffff);
    send_item(KIND_INSERT, 4'h0, 16'h0000);
    send_item(KIND_INSERT, 4'h7, 16'h1234);
    send_item(KIND_INSERT, 4'h7, 16'hedcb);
    send_item(KindUnused,  4'h5, 16'h5a5a);
    repeat (2) send_item(KIND_REMOVE, 4'h0, 16'h0000);
    send_item(KIND_CLEAR,  4'ha, 16'ha5a5);
    send_item(KIND_REMOVE, 4'h0, 16'h0000);
    send_item(KIND_INSERT, 4'h8, 16'haaaa);
    send_item(KIND_INSERT, 4'h8, 16'h5555);
    send_item(KIND_INSERT, 4'h3, 16'h0f0f);
    repeat (4) send_item(KIND_REMOVE, 4'h0, 16'h0000);

    // random: segments biased toward filling or draining the queue
    sent = 0;
    seg  = 0;
    while (sent < RandomItems) begin
      case (seg % 4)
        0:       ins_pct = 85;
        1:       ins_pct = 30;
        2:       ins_pct = 55;
        default: ins_pct = 75;
      endcase
      narrow = ($urandom_range(0, 2) == 0);  // few priorities, many ties
      steady = (seg % 5 == 3);
      if (seg == 0 || seg == 12) hold_req = 1'b1;
      repeat (SegmentLen) begin
        k = pick_kind(ins_pct);
        send_item(k, narrow ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15)),
                  16'($urandom));
        if (k != KindUnused) sent++;
      end
      seg++;
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    // let the checker record the last transaction before polling its backlog
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Ran %0d inserts, %0d removes, %0d clears, %0d unused-kind transactions.",
             kind_sent[KIND_INSERT], kind_sent[KIND_REMOVE], kind_sent[KIND_CLEAR],
             kind_sent[KindUnused]);
    $display("Hit full %0d times, empty %0d times, peak fill %0d, with long receiver holds.",
             full_hits, empty_hits, peak_fill);
    if (fail_count == 0 && pending == 0) begin
      $display("sorted_priority_queue_top test passed");
    end else begin
      $display("sorted_priority_queue_top test failed");
    end
    $finish;
  end

endmodule

/* sorted_priority_queue_top.f */
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_top.sv
sim/spq_checker.sv
sim/tb_sorted_priority_queue_top.sv
